### rtl/sdf_pkg.sv
// Shared widths, register indexes and word types of the spring-damper force core.
package sdf_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int REG_BITS  = WORD_BITS - 1;

    // difference of two words, and its magnitude
    localparam int DW    = WORD_BITS + 1;
    // sum of three squared differences
    localparam int SQW   = 2 * DW;
    // square root result and its partial remainder
    localparam int RTW   = DW;
    localparam int REMW  = RTW + 3;
    // unit vector magnitude (never above 1.0) and divider remainder
    localparam int QW    = FRAC_BITS + 1;
    localparam int DREMW = DW + 1;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STIFFNESS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DAMPING     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REST_LENGTH = 2'd2;

    localparam logic [REG_BITS-1:0] STIFFNESS_RST   = REG_BITS'(1 << FRAC_BITS);
    localparam logic [REG_BITS-1:0] DAMPING_RST     = '0;
    localparam logic [REG_BITS-1:0] REST_LENGTH_RST = REG_BITS'(1 << FRAC_BITS);

    typedef struct packed {
        logic signed [WORD_BITS-1:0] first_pos_x;
        logic signed [WORD_BITS-1:0] first_pos_y;
        logic signed [WORD_BITS-1:0] first_pos_z;
        logic signed [WORD_BITS-1:0] second_pos_x;
        logic signed [WORD_BITS-1:0] second_pos_y;
        logic signed [WORD_BITS-1:0] second_pos_z;
        logic signed [WORD_BITS-1:0] first_vel_x;
        logic signed [WORD_BITS-1:0] first_vel_y;
        logic signed [WORD_BITS-1:0] first_vel_z;
        logic signed [WORD_BITS-1:0] second_vel_x;
        logic signed [WORD_BITS-1:0] second_vel_y;
        logic signed [WORD_BITS-1:0] second_vel_z;
    } sdf_in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] force_x;
        logic signed [WORD_BITS-1:0] force_y;
        logic signed [WORD_BITS-1:0] force_z;
        logic                        degenerate;
    } sdf_out_t;

    // per-item data carried down the square root and divider stages
    typedef struct packed {
        logic [2:0][DW-1:0] d_mag;
        logic [2:0]         d_neg;
        logic [2:0][DW-1:0] dv;
    } sdf_car_t;

    typedef struct packed {
        sdf_car_t          car;
        logic [SQW-1:0]    s;
        logic [REMW-1:0]   rem;
        logic [RTW-1:0]    root;
    } sdf_sqrt_t;

    typedef struct packed {
        sdf_car_t              car;
        logic [RTW-1:0]        seg_len;
        logic [2:0][DREMW-1:0] rem;
        logic [2:0][QW-1:0]    nb;
        logic [2:0][QW-1:0]    quo;
    } sdf_div_t;

endpackage

### rtl/spring_damper_force_core.sv
// Spring-damper force core: distance, unit vector and force in a 59-stage pipeline.
//
// Input channel in_valid/in_ready/in_data carries one word per spring: both
// particle positions and velocities in signed Q16.16. Output channel
// out_valid/out_ready/out_data returns the force on the first particle,
// saturated to 32 bits, and a degenerate flag when the positions coincide
// (force is then zero).
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes
// stiffness (0), damping (1) and rest length (2); other indexes are ignored.
// cfg_ready is always high. Write configuration only while no word is in flight.
// A word passes 59 register stages: 3 stages form the differences and squared
// distance, 33 stages of the square root give one root bit each, 17 divider
// stages give one unit-vector bit each, and 6 stages form the products and
// sums and saturate the force. Throughput is one word per cycle while the
// receiver does not stall. All stages advance together whenever the output
// register is empty or being taken; when the receiver stalls, the whole pipeline
// holds and in_ready drops in the same cycle, so nothing is lost.
// Reset clears all valid bits and loads the register reset values
// (stiffness 1.0, damping 0, rest length 1.0).
module spring_damper_force_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  sdf_pkg::sdf_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sdf_pkg::sdf_out_t                  out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sdf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [sdf_pkg::WORD_BITS-1:0]      cfg_data
);
    import sdf_pkg::*;

    localparam int NST   = 3 + RTW + QW + 6;
    localparam int XW    = RTW + 2;
    localparam int PDW   = DW + QW;
    localparam int PFW   = REG_BITS + XW - 1;
    localparam int DOTW  = DW + 3;
    localparam int FSW   = PFW - FRAC_BITS + 1;
    localparam int LOW   = DOTW / 2;
    localparam int PPW   = REG_BITS + LOW;
    localparam int FDW   = PPW + (DOTW - LOW);
    localparam int FSDW  = FSW + 4;
    localparam int HALF  = FSDW / 2;
    localparam int APW   = (FSDW - HALF) + QW;
    localparam int FPW   = APW + HALF;
    localparam int MW    = FPW - FRAC_BITS;
    localparam logic [MW-1:0] POS_LIM = MW'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [MW-1:0] NEG_LIM = MW'(64'd1 << (WORD_BITS - 1));

    typedef struct packed {
        logic [2:0][PDW-1:0] pd;
        logic [2:0]          pd_neg;
        logic [PFW-1:0]      pf;
        logic                pf_neg;
        logic [2:0][QW-1:0]  e_mag;
        logic [2:0]          e_neg;
        logic                deg;
    } p1_t;

    typedef struct packed {
        logic signed [DOTW-1:0] dot;
        logic signed [FSW-1:0]  fs;
        logic [2:0][QW-1:0]     e_mag;
        logic [2:0]             e_neg;
        logic                   deg;
    } p2_t;

    typedef struct packed {
        logic [PPW-1:0]        pp_lo;
        logic [PPW-1:0]        pp_hi;
        logic                  dot_neg;
        logic signed [FSW-1:0] fs;
        logic [2:0][QW-1:0]    e_mag;
        logic [2:0]            e_neg;
        logic                  deg;
    } p3_t;

    typedef struct packed {
        logic signed [FSDW-1:0] fsd;
        logic [2:0][QW-1:0]     e_mag;
        logic [2:0]             e_neg;
        logic                   deg;
    } p4_t;

    typedef struct packed {
        logic [2:0][APW-1:0] a_lo;
        logic [2:0][APW-1:0] a_hi;
        logic [2:0]          neg;
        logic                deg;
    } p5_t;

    logic [REG_BITS-1:0] stiffness_reg;
    logic [REG_BITS-1:0] damping_reg;
    logic [REG_BITS-1:0] rest_length_reg;

    logic [NST-1:0] vld_reg;
    logic           adv;

    sdf_car_t       a_reg, a_next;
    sdf_car_t       b_car_reg;
    logic [SQW-1:0] b_sq_reg [3];
    logic [SQW-1:0] b_sq_next [3];
    sdf_car_t       c_car_reg;
    logic [SQW-1:0] c_s_reg, c_s_next;

    sdf_sqrt_t sq_reg [RTW];
    sdf_sqrt_t sq_cur [RTW];
    sdf_sqrt_t sq_next [RTW];
    sdf_div_t  dv_reg [QW];
    sdf_div_t  dv_cur [QW];
    sdf_div_t  dv_next [QW];

    p1_t      p1_reg, p1_next;
    p2_t      p2_reg, p2_next;
    p3_t      p3_reg, p3_next;
    p4_t      p4_reg, p4_next;
    p5_t      p5_reg, p5_next;
    sdf_out_t out_reg, out_next;

    // all stages move together; the output register is the last stage
    assign adv       = !vld_reg[NST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NST-1];
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg   <= STIFFNESS_RST;
            damping_reg     <= DAMPING_RST;
            rest_length_reg <= REST_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STIFFNESS:   stiffness_reg   <= cfg_data[REG_BITS-1:0];
                CFG_DAMPING:     damping_reg     <= cfg_data[REG_BITS-1:0];
                CFG_REST_LENGTH: rest_length_reg <= cfg_data[REG_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // position differences, their magnitudes and signs, and velocity differences
    always_comb
    begin
        logic signed [WORD_BITS-1:0] fp [3];
        logic signed [WORD_BITS-1:0] sp [3];
        logic signed [WORD_BITS-1:0] fv [3];
        logic signed [WORD_BITS-1:0] sv [3];
        logic signed [DW-1:0]        d;
        fp[0] = in_data.first_pos_x;  fp[1] = in_data.first_pos_y;  fp[2] = in_data.first_pos_z;
        sp[0] = in_data.second_pos_x; sp[1] = in_data.second_pos_y; sp[2] = in_data.second_pos_z;
        fv[0] = in_data.first_vel_x;  fv[1] = in_data.first_vel_y;  fv[2] = in_data.first_vel_z;
        sv[0] = in_data.second_vel_x; sv[1] = in_data.second_vel_y; sv[2] = in_data.second_vel_z;
        for (int i = 0; i < 3; i++)
        begin
            d = DW'(sp[i]) - DW'(fp[i]);
            a_next.d_neg[i] = d[DW-1];
            a_next.d_mag[i] = d[DW-1] ? DW'(-d) : DW'(d);
            a_next.dv[i]    = DW'(DW'(sv[i]) - DW'(fv[i]));
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_sq_next[i] = SQW'(a_reg.d_mag[i]) * SQW'(a_reg.d_mag[i]);
        end
        c_s_next = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
    end

    // square root: one root bit per stage, two radicand bits shifted in each time
    always_comb
    begin
        logic [REMW-1:0] r_sh;
        logic [REMW-1:0] trial;
        sq_cur[0].car  = c_car_reg;
        sq_cur[0].s    = c_s_reg;
        sq_cur[0].rem  = '0;
        sq_cur[0].root = '0;
        for (int k = 1; k < RTW; k++)
        begin
            sq_cur[k] = sq_reg[k-1];
        end
        for (int k = 0; k < RTW; k++)
        begin
            r_sh  = {sq_cur[k].rem[REMW-3:0], sq_cur[k].s[SQW-1 -: 2]};
            trial = REMW'({sq_cur[k].root, 2'b01});
            sq_next[k]     = sq_cur[k];
            sq_next[k].s   = {sq_cur[k].s[SQW-3:0], 2'b00};
            if (r_sh >= trial)
            begin
                sq_next[k].rem  = r_sh - trial;
                sq_next[k].root = {sq_cur[k].root[RTW-2:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem  = r_sh;
                sq_next[k].root = {sq_cur[k].root[RTW-2:0], 1'b0};
            end
        end
    end

    // unit vector: |d| * 2^FRAC / distance, one quotient bit per stage for all lanes
    always_comb
    begin
        logic [DREMW-1:0] r_sh;
        dv_cur[0].car     = sq_reg[RTW-1].car;
        dv_cur[0].seg_len = sq_reg[RTW-1].root;
        for (int i = 0; i < 3; i++)
        begin
            dv_cur[0].rem[i] = DREMW'(sq_reg[RTW-1].car.d_mag[i][DW-1:1]);
            dv_cur[0].nb[i]  = {sq_reg[RTW-1].car.d_mag[i][0], {FRAC_BITS{1'b0}}};
            dv_cur[0].quo[i] = '0;
        end
        for (int k = 1; k < QW; k++)
        begin
            dv_cur[k] = dv_reg[k-1];
        end
        for (int k = 0; k < QW; k++)
        begin
            dv_next[k] = dv_cur[k];
            for (int i = 0; i < 3; i++)
            begin
                r_sh = {dv_cur[k].rem[i][DREMW-2:0], dv_cur[k].nb[i][QW-1]};
                dv_next[k].nb[i] = {dv_cur[k].nb[i][QW-2:0], 1'b0};
                if (r_sh >= DREMW'(dv_cur[k].seg_len))
                begin
                    dv_next[k].rem[i] = r_sh - DREMW'(dv_cur[k].seg_len);
                    dv_next[k].quo[i] = {dv_cur[k].quo[i][QW-2:0], 1'b1};
                end
                else
                begin
                    dv_next[k].rem[i] = r_sh;
                    dv_next[k].quo[i] = {dv_cur[k].quo[i][QW-2:0], 1'b0};
                end
            end
        end
    end

    // velocity projection products and spring product
    always_comb
    begin
        logic signed [DW-1:0] dvs;
        logic [DW-1:0]        dvm;
        logic signed [XW-1:0] x;
        for (int i = 0; i < 3; i++)
        begin
            dvs = $signed(dv_reg[QW-1].car.dv[i]);
            dvm = dvs[DW-1] ? DW'(-dvs) : DW'(dvs);
            p1_next.pd[i]     = PDW'(dvm) * PDW'(dv_reg[QW-1].quo[i]);
            p1_next.pd_neg[i] = dvs[DW-1] ^ dv_reg[QW-1].car.d_neg[i];
            p1_next.e_mag[i]  = dv_reg[QW-1].quo[i];
            p1_next.e_neg[i]  = dv_reg[QW-1].car.d_neg[i];
        end
        x = $signed(XW'(dv_reg[QW-1].seg_len)) - $signed(XW'(rest_length_reg));
        p1_next.pf_neg = x[XW-1];
        p1_next.pf     = PFW'(stiffness_reg)
                       * PFW'(x[XW-1] ? (XW-1)'(-x) : (XW-1)'(x));
        p1_next.deg    = (dv_reg[QW-1].seg_len == '0);
    end

    // truncate toward zero, apply signs, sum the dot product
    always_comb
    begin
        logic signed [DOTW-1:0] t;
        logic signed [DOTW-1:0] acc;
        logic signed [FSW-1:0]  fsm;
        acc = '0;
        for (int i = 0; i < 3; i++)
        begin
            t   = $signed(DOTW'(p1_reg.pd[i][PDW-1:FRAC_BITS]));
            acc = acc + (p1_reg.pd_neg[i] ? -t : t);
        end
        fsm           = $signed(FSW'(p1_reg.pf[PFW-1:FRAC_BITS]));
        p2_next.dot   = acc;
        p2_next.fs    = p1_reg.pf_neg ? -fsm : fsm;
        p2_next.e_mag = p1_reg.e_mag;
        p2_next.e_neg = p1_reg.e_neg;
        p2_next.deg   = p1_reg.deg;
    end

    // damping times |dot|, split in two partial products
    always_comb
    begin
        logic [DOTW-1:0] dm;
        dm = p2_reg.dot[DOTW-1] ? DOTW'(-p2_reg.dot) : DOTW'(p2_reg.dot);
        p3_next.pp_lo   = PPW'(damping_reg) * PPW'(dm[LOW-1:0]);
        p3_next.pp_hi   = PPW'(damping_reg) * PPW'(dm[DOTW-1:LOW]);
        p3_next.dot_neg = p2_reg.dot[DOTW-1];
        p3_next.fs      = p2_reg.fs;
        p3_next.e_mag   = p2_reg.e_mag;
        p3_next.e_neg   = p2_reg.e_neg;
        p3_next.deg     = p2_reg.deg;
    end

    // combine partial products, add spring and damping terms
    always_comb
    begin
        logic [FDW-1:0]         prod;
        logic signed [FSDW-1:0] fdm;
        prod = FDW'(p3_reg.pp_lo) + (FDW'(p3_reg.pp_hi) << LOW);
        fdm  = $signed(FSDW'(prod[FDW-1:FRAC_BITS]));
        p4_next.fsd   = FSDW'(p3_reg.fs) + (p3_reg.dot_neg ? -fdm : fdm);
        p4_next.e_mag = p3_reg.e_mag;
        p4_next.e_neg = p3_reg.e_neg;
        p4_next.deg   = p3_reg.deg;
    end

    // scalar force times unit vector, split in two partial products
    always_comb
    begin
        logic [FSDW-1:0] fm;
        fm = p4_reg.fsd[FSDW-1] ? FSDW'(-p4_reg.fsd) : FSDW'(p4_reg.fsd);
        for (int i = 0; i < 3; i++)
        begin
            p5_next.a_lo[i] = APW'(fm[HALF-1:0]) * APW'(p4_reg.e_mag[i]);
            p5_next.a_hi[i] = APW'(fm[FSDW-1:HALF]) * APW'(p4_reg.e_mag[i]);
            p5_next.neg[i]  = p4_reg.fsd[FSDW-1] ^ p4_reg.e_neg[i];
        end
        p5_next.deg = p4_reg.deg;
    end

    // combine, truncate, saturate to a word
    always_comb
    begin
        logic [FPW-1:0]       prod;
        logic [MW-1:0]        m;
        logic [WORD_BITS-1:0] f [3];
        for (int i = 0; i < 3; i++)
        begin
            prod = FPW'(p5_reg.a_lo[i]) + (FPW'(p5_reg.a_hi[i]) << HALF);
            m    = prod[FPW-1:FRAC_BITS];
            if (p5_reg.deg)
                f[i] = '0;
            else if (p5_reg.neg[i])
                f[i] = (m > NEG_LIM) ? WORD_BITS'(NEG_LIM) : WORD_BITS'(-m);
            else
                f[i] = (m > POS_LIM) ? WORD_BITS'(POS_LIM) : WORD_BITS'(m);
        end
        out_next.force_x    = f[0];
        out_next.force_y    = f[1];
        out_next.force_z    = f[2];
        out_next.degenerate = p5_reg.deg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg     <= a_next;
            b_car_reg <= a_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[i] <= b_sq_next[i];
            end
            c_car_reg <= b_car_reg;
            c_s_reg   <= c_s_next;
            for (int k = 0; k < RTW; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            for (int k = 0; k < QW; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            p4_reg  <= p4_next;
            p5_reg  <= p5_next;
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.force_x == '0 && out_data.force_y == '0 && out_data.force_z == '0)
        else $error("degenerate word carries nonzero force");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output register is empty");

    a_cfg_stiffness: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == CFG_STIFFNESS |=>
            stiffness_reg == $past(cfg_data[REG_BITS-1:0]))
        else $error("stiffness write not taken");
`endif

endmodule

### bench/spring_damper_force_core_tb.sv
// Self-checking bench for the spring-damper force core: scoreboard, drivers and phases.
module spring_damper_force_core_tb;
    import sdf_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int LATENCY     = 59;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;
    localparam logic [127:0] CLAMP_LIM = (128'd1 << 62) - 128'd1;

    class force_board;
        longint stiffness, damping, rest_length;
        sdf_out_t expected_forces[$];
        int errors, checked, degenerate_seen;

        function new();
            stiffness   = longint'(STIFFNESS_RST);
            damping     = longint'(DAMPING_RST);
            rest_length = longint'(REST_LENGTH_RST);
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
            longint v;
            v = longint'(data[REG_BITS-1:0]);
            case (idx)
                CFG_STIFFNESS:   stiffness = v;
                CFG_DAMPING:     damping = v;
                CFG_REST_LENGTH: rest_length = v;
                default: ;
            endcase
        endfunction

        // product shifted right by the fraction bits, toward zero, magnitude clamped
        function longint fixed_mul(longint a, longint b);
            logic [63:0] ma, mb, m;
            logic [127:0] p;
            ma = a < 0 ? 64'(-a) : 64'(a);
            mb = b < 0 ? 64'(-b) : 64'(b);
            p = ({64'd0, ma} * {64'd0, mb}) >> FRAC_BITS;
            m = (p > CLAMP_LIM) ? CLAMP_LIM[63:0] : p[63:0];
            return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
        endfunction

        function sdf_out_t predict_force(sdf_in_t w);
            longint d[3], dv[3], e[3], fs, fd, fsd, dot, f;
            logic [127:0] s, c2, n;
            logic [63:0] seg_len, c, m;
            sdf_out_t r;
            d[0] = longint'(w.second_pos_x) - longint'(w.first_pos_x);
            d[1] = longint'(w.second_pos_y) - longint'(w.first_pos_y);
            d[2] = longint'(w.second_pos_z) - longint'(w.first_pos_z);
            dv[0] = longint'(w.second_vel_x) - longint'(w.first_vel_x);
            dv[1] = longint'(w.second_vel_y) - longint'(w.first_vel_y);
            dv[2] = longint'(w.second_vel_z) - longint'(w.first_vel_z);
            s = '0;
            for (int i = 0; i < 3; i++) begin
                m = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
                s += {64'd0, m} * {64'd0, m};
            end
            seg_len = '0;
            for (int b = 63; b >= 0; b--) begin
                c = seg_len | (64'd1 << b);
                c2 = {64'd0, c} * {64'd0, c};
                if (c2 <= s) seg_len = c;
            end
            r = '0;
            if (seg_len == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
            for (int i = 0; i < 3; i++) begin
                m = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
                n = ({64'd0, m} << FRAC_BITS) / {64'd0, seg_len};
                e[i] = d[i] < 0 ? -longint'(n[63:0]) : longint'(n[63:0]);
            end
            fs = fixed_mul(stiffness, longint'(seg_len) - rest_length);
            dot = 0;
            for (int i = 0; i < 3; i++) dot += fixed_mul(dv[i], e[i]);
            fd = fixed_mul(damping, dot);
            fsd = fs + fd;
            for (int i = 0; i < 3; i++) begin
                f = fixed_mul(fsd, e[i]);
                if (f > 64'sd2147483647) f = 64'sd2147483647;
                if (f < -64'sd2147483648) f = -64'sd2147483648;
                case (i)
                    0: r.force_x = f[31:0];
                    1: r.force_y = f[31:0];
                    default: r.force_z = f[31:0];
                endcase
            end
            return r;
        endfunction

        function void note_spring(sdf_in_t w);
            expected_forces.push_back(predict_force(w));
        endfunction

        function void check_force(sdf_out_t got);
            sdf_out_t want;
            if (expected_forces.size() == 0) begin
                $error("force word with nothing expected: %h", got);
                errors++;
                return;
            end
            want = expected_forces.pop_front();
            checked++;
            if (want.degenerate) degenerate_seen++;
            if (got.force_x !== want.force_x) begin
                $error("force_x expected %0d actual %0d", want.force_x, got.force_x);
                errors++;
            end
            if (got.force_y !== want.force_y) begin
                $error("force_y expected %0d actual %0d", want.force_y, got.force_y);
                errors++;
            end
            if (got.force_z !== want.force_z) begin
                $error("force_z expected %0d actual %0d", want.force_z, got.force_z);
                errors++;
            end
            if (got.degenerate !== want.degenerate) begin
                $error("degenerate expected %0b actual %0b", want.degenerate, got.degenerate);
                errors++;
            end
        endfunction

        function int pending();
            return expected_forces.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    sdf_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sdf_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [WORD_BITS-1:0] cfg_data = '0;

    force_board sb = new();
    bit hold_req = 1'b0;
    bit quiet_sender = 1'b0;
    int sent = 0;
    int idle_cycles = 0;

    spring_damper_force_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_force(out_data);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int run_len, stall;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            run_len = $urandom_range(1, 40);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic send_spring(sdf_in_t w);
        int gap;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_spring(w);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
        drain();
        repeat (LATENCY + 5) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    function automatic sdf_in_t make_spring(int px, int py, int pz, int qx, int qy, int qz,
                                            int ux, int uy, int uz, int vx, int vy, int vz);
        sdf_in_t w;
        w.first_pos_x = px;  w.first_pos_y = py;  w.first_pos_z = pz;
        w.second_pos_x = qx; w.second_pos_y = qy; w.second_pos_z = qz;
        w.first_vel_x = ux;  w.first_vel_y = uy;  w.first_vel_z = uz;
        w.second_vel_x = vx; w.second_vel_y = vy; w.second_vel_z = vz;
        return w;
    endfunction

    function automatic int near(int base, int span);
        return base + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic sdf_in_t random_spring();
        sdf_in_t w;
        int r, bx, by, bz;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            // mesh-like spring: nearby particles, moderate velocities, some coincident or nearly so
            bx = near(0, 1 << 22); by = near(0, 1 << 22); bz = near(0, 1 << 22);
            w = make_spring(bx, by, bz,
                            near(bx, 1 << 18), near(by, 1 << 18), near(bz, 1 << 18),
                            near(0, 1 << 20), near(0, 1 << 20), near(0, 1 << 20),
                            near(0, 1 << 20), near(0, 1 << 20), near(0, 1 << 20));
            if (r < 25) begin
                w.second_pos_x = w.first_pos_x;
                w.second_pos_y = w.first_pos_y;
                w.second_pos_z = w.first_pos_z;
            end else if (r < 32) begin
                w.second_pos_y = w.first_pos_y;
                w.second_pos_z = w.first_pos_z;
                w.second_pos_x = w.first_pos_x + $signed($urandom_range(0, 8)) - 4;
            end
        end
        return w;
    endfunction

    task automatic random_run(int count, bit with_hold, bit with_pause);
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 3) begin
                hold_req = 1'b1;
                quiet_sender = 1'b1;
            end
            if (with_hold && i == count / 3 + 120) quiet_sender = 1'b0;
            if (with_pause && i == count / 2) drain();
            send_spring(random_spring());
        end
    endtask

    localparam int MAXP = 32'h7fffffff;
    localparam int MINN = 32'h80000000;

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed springs under reset register values
        send_spring(make_spring(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_spring(make_spring(MINN, MINN, MINN, MINN, MINN, MINN,
                                MAXP, MAXP, MAXP, MINN, MINN, MINN));
        send_spring(make_spring(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, 0, 0, 0, 0, 0, 0));
        send_spring(make_spring(MINN, MINN, MINN, MAXP, MAXP, MAXP,
                                MINN, MINN, MINN, MAXP, MAXP, MAXP));
        send_spring(make_spring(MAXP, MAXP, MAXP, MINN, MINN, MINN,
                                MAXP, MAXP, MAXP, MINN, MINN, MINN));
        send_spring(make_spring(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_spring(make_spring(0, 0, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0));
        send_spring(make_spring(0, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 0, 0));
        send_spring(make_spring(0, 0, 0, 131072, 0, 0, 0, 0, 0, 65536, 0, 0));
        send_spring(make_spring(0, 0, 0, 65536, 65536, 65536, 0, 0, 0, -65536, 0, 0));
        send_spring(make_spring(MINN, 0, 0, MAXP, 0, 0, 0, 0, 0, 0, 0, 0));
        send_spring(make_spring(0, MAXP, 0, 0, MINN, 0, 0, 0, 0, 0, 0, 0));
        send_spring(make_spring(5, 7, -3, 5, 7, -3, MAXP, MINN, 1, -1, MAXP, MINN));

        write_cfg(CFG_STIFFNESS, 32'h7fffffff);
        write_cfg(CFG_DAMPING, 32'h7fffffff);
        write_cfg(CFG_REST_LENGTH, 32'h0);
        send_spring(make_spring(0, 0, 0, 65536, 0, 0, MINN, 0, 0, MAXP, 0, 0));
        send_spring(make_spring(MINN, MINN, MINN, MAXP, MAXP, MAXP,
                                MAXP, MAXP, MAXP, MINN, MINN, MINN));
        send_spring(make_spring(0, 0, 0, 1, 1, 1, MINN, MINN, MINN, MAXP, MAXP, MAXP));
        send_spring(make_spring(0, 0, 0, 0, 0, 0, MINN, MINN, MINN, MAXP, MAXP, MAXP));
        random_run(200, 1'b1, 1'b1);

        // masked data and an ignored index
        write_cfg(CFG_STIFFNESS, 32'h80000000);
        write_cfg(CFG_DAMPING, 32'hffffffff);
        write_cfg(CFG_REST_LENGTH, 32'hffffffff);
        write_cfg(CFG_UNUSED, 32'h12345678);
        send_spring(make_spring(0, 0, 0, MAXP, 0, 0, 0, 0, 0, 0, 0, 0));
        random_run(200, 1'b0, 1'b0);

        for (int ph = 0; ph < 5; ph++) begin
            write_cfg(CFG_STIFFNESS, ph == 0 ? 32'h1 : {1'b0, 31'($urandom_range(0, 1 << 22))});
            write_cfg(CFG_DAMPING, ph == 1 ? 32'h0 : {1'b0, 31'($urandom_range(0, 1 << 20))});
            write_cfg(CFG_REST_LENGTH, ph == 2 ? $urandom : {1'b0, 31'($urandom_range(0, 1 << 19))});
            random_run(225, ph == 3, ph == 4);
        end

        drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d expected force words never arrived", sb.pending());
            sb.errors++;
        end
        $display("springs sent %0d, force words checked %0d, coincident cases %0d",
                 sent, sb.checked, sb.degenerate_seen);
        $display("covered reset, extreme and random register settings with stalls on both sides");
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### files.f
rtl/sdf_pkg.sv
rtl/spring_damper_force_core.sv
bench/spring_damper_force_core_tb.sv
